// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the timer table RTL.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CTST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising clock edge, reset included.
`define CTST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/ctst_pkg.sv =====
// Shared types and constants of the countdown timer slot table.
// Depends on nothing.
package ctst_pkg;

    localparam int unsigned KIND_W     = 2;
    localparam int unsigned OUT_SLOT_W = 5;
    localparam int unsigned OUT_TAG_W  = 8;
    localparam int unsigned IN_COUNT_W = 32;
    localparam int unsigned IN_TAG_W   = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED   = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_EXPIRED = 2'd2
    } t_kind;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_ADD  = 1'b1
    } t_cmd;

endpackage

// ===== rtl/ctst_cell.sv =====
// One slot of the timer ring: valid flag, remaining count and tag.
// Shifts its contents to the neighboring cell when enabled. Uses no package.
module ctst_cell #(
    parameter int unsigned CW = 32,
    parameter int unsigned TW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  logic          i_valid,
    input  logic [CW-1:0] i_count,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [CW-1:0] o_count,
    output logic [TW-1:0] o_tag
);

    logic          r_valid;
    logic [CW-1:0] r_count;
    logic [TW-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
        if (i_shift) begin
            r_count <= i_count;
            r_tag   <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_count = r_count;
    assign o_tag   = r_tag;

endmodule

// ===== rtl/countdown_timer_slot_table.sv =====
// Table of SLOTS one-shot countdown timers kept in a ring of cells. Every item walks the
// whole ring once: the slot at the head cell is examined, updated and passed to the tail,
// one slot per cycle while no expiry is held by a stalled output; the block takes no new item
// until the walk is over and its last beat, if any, is loaded for output. An add answers
// with the lowest free slot or "table full"; a tick gives one expiry beat per slot that
// reaches zero, in slot order, the final one marked by o_last, and no beat if none expires.
// Depends on ctst_pkg, ctst_cell and assert_macros.svh.
`include "assert_macros.svh"

module countdown_timer_slot_table #(
    parameter int unsigned SLOTS      = 32,
    parameter int unsigned COUNT_BITS = 32,
    parameter int unsigned TAG_BITS   = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic [ctst_pkg::IN_COUNT_W-1:0]     i_count,
    input  logic [ctst_pkg::IN_TAG_W-1:0]       i_tag,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ctst_pkg::KIND_W-1:0]         o_kind,
    output logic [ctst_pkg::OUT_SLOT_W-1:0]     o_slot,
    output logic [ctst_pkg::OUT_TAG_W-1:0]      o_expired_tag,
    output logic                                o_last
);
    import ctst_pkg::*;

    localparam int unsigned IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_STEP = IW'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_step, n_step;
    t_cmd                  r_cmd, n_cmd;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [TAG_BITS-1:0]   r_tag, n_tag;
    logic                  r_found, n_found;
    logic [IW-1:0]         r_found_slot, n_found_slot;
    logic                  r_pend_valid, n_pend_valid;
    logic [IW-1:0]         r_pend_slot, n_pend_slot;
    logic [TAG_BITS-1:0]   r_pend_tag, n_pend_tag;
    logic                  r_o_valid, n_o_valid;
    t_kind                 r_o_kind, n_o_kind;
    logic [IW-1:0]         r_o_slot, n_o_slot;
    logic [TAG_BITS-1:0]   r_o_tag, n_o_tag;
    logic                  r_o_last, n_o_last;

    // Ring wiring: cell k takes from cell k+1, the tail takes the processed head.
    logic                  c_valid [SLOTS];
    logic [COUNT_BITS-1:0] c_count [SLOTS];
    logic [TAG_BITS-1:0]   c_tag   [SLOTS];
    logic                  w_valid [SLOTS];
    logic [COUNT_BITS-1:0] w_count [SLOTS];
    logic [TAG_BITS-1:0]   w_tag   [SLOTS];

    logic                  w_shift;
    logic                  w_out_free;
    logic                  w_expire;
    logic                  w_adv;
    logic [COUNT_BITS-1:0] w_dec;
    logic                  w_new_valid;
    logic [COUNT_BITS-1:0] w_new_count;
    logic [TAG_BITS-1:0]   w_new_tag;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            if (g == SLOTS - 1) begin : g_tail
                assign w_valid[g] = w_new_valid;
                assign w_count[g] = w_new_count;
                assign w_tag[g]   = w_new_tag;
            end else begin : g_mid
                assign w_valid[g] = c_valid[g+1];
                assign w_count[g] = c_count[g+1];
                assign w_tag[g]   = c_tag[g+1];
            end
            ctst_cell #(
                .CW (COUNT_BITS),
                .TW (TAG_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_valid (w_valid[g]),
                .i_count (w_count[g]),
                .i_tag   (w_tag[g]),
                .o_valid (c_valid[g]),
                .o_count (c_count[g]),
                .o_tag   (c_tag[g])
            );
        end
    endgenerate

    assign w_out_free = !r_o_valid || i_ready;
    assign w_dec      = c_count[0] - COUNT_BITS'(1);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_tag        = r_tag;
        n_found      = r_found;
        n_found_slot = r_found_slot;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_pend_tag   = r_pend_tag;
        n_o_valid    = r_o_valid;
        n_o_kind     = r_o_kind;
        n_o_slot     = r_o_slot;
        n_o_tag      = r_o_tag;
        n_o_last     = r_o_last;
        w_shift      = 1'b0;
        w_expire     = 1'b0;
        w_adv        = 1'b0;
        w_new_valid  = c_valid[0];
        w_new_count  = c_count[0];
        w_new_tag    = c_tag[0];

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_count = COUNT_BITS'(i_count);
                    n_tag   = TAG_BITS'(i_tag);
                    n_step  = '0;
                    n_found = 1'b0;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_cmd == CMD_ADD) begin
                    if (!c_valid[0] && !r_found) begin
                        w_new_valid = 1'b1;
                        w_new_count = r_count;
                        w_new_tag   = r_tag;
                    end
                end else if (c_valid[0]) begin
                    w_new_count = w_dec;
                    if (w_dec == '0) begin
                        w_new_valid = 1'b0;
                        w_expire    = 1'b1;
                    end
                end
                // An expiry can only be held back once the previous one is handed on,
                // because it is not known to be the last until the walk ends.
                w_adv = !(w_expire && r_pend_valid) || w_out_free;
                if (w_adv) begin
                    w_shift = 1'b1;
                    n_step  = r_step + IW'(1);
                    if (r_step == LAST_STEP) begin
                        n_state = ST_DONE;
                    end
                    if (r_cmd == CMD_ADD && !c_valid[0] && !r_found) begin
                        n_found      = 1'b1;
                        n_found_slot = r_step;
                    end
                    if (w_expire) begin
                        if (r_pend_valid) begin
                            n_o_valid = 1'b1;
                            n_o_kind  = KIND_EXPIRED;
                            n_o_slot  = r_pend_slot;
                            n_o_tag   = r_pend_tag;
                            n_o_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = r_step;
                        n_pend_tag   = c_tag[0];
                    end
                end
            end
            ST_DONE: begin
                if (r_cmd == CMD_ADD) begin
                    if (w_out_free) begin
                        n_o_valid = 1'b1;
                        n_o_kind  = r_found ? KIND_ADDED : KIND_FULL;
                        n_o_slot  = r_found ? r_found_slot : '0;
                        n_o_tag   = r_tag;
                        n_o_last  = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end else if (r_pend_valid) begin
                    if (w_out_free) begin
                        n_o_valid    = 1'b1;
                        n_o_kind     = KIND_EXPIRED;
                        n_o_slot     = r_pend_slot;
                        n_o_tag      = r_pend_tag;
                        n_o_last     = 1'b1;
                        n_pend_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_found      <= n_found;
            r_pend_valid <= n_pend_valid;
            r_o_valid    <= n_o_valid;
        end
        r_cmd        <= n_cmd;
        r_count      <= n_count;
        r_tag        <= n_tag;
        r_found_slot <= n_found_slot;
        r_pend_slot  <= n_pend_slot;
        r_pend_tag   <= n_pend_tag;
        r_o_kind     <= n_o_kind;
        r_o_slot     <= n_o_slot;
        r_o_tag      <= n_o_tag;
        r_o_last     <= n_o_last;
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_slot        = OUT_SLOT_W'(r_o_slot);
    assign o_expired_tag = OUT_TAG_W'(r_o_tag);
    assign o_last        = r_o_last;

    `CTST_ASSERT(a_idle_no_pend,
        (r_state == ST_IDLE) |-> !r_pend_valid,
        "expiry left pending at idle")
    `CTST_ASSERT(a_accept_walk,
        (i_valid && o_ready) |=> (r_state == ST_WALK && r_step == '0),
        "accepted beat did not start a walk")
    `CTST_ASSERT(a_pend_tick,
        r_pend_valid |-> (r_cmd == CMD_TICK),
        "pending expiry during an add")
    `CTST_ASSERT_ALWAYS(a_reset_idle,
        !i_rst_n |=> (r_state == ST_IDLE && !r_o_valid),
        "reset did not clear control")

endmodule
